// File: rtl/crt_pkg.sv
package crt_pkg;

  // Request codes of an input transaction
  localparam logic [2:0] REQ_ENQUEUE = 3'd0;
  localparam logic [2:0] REQ_SENT    = 3'd1;
  localparam logic [2:0] REQ_TICK    = 3'd2;
  localparam logic [2:0] REQ_REPLY   = 3'd3;
  localparam logic [2:0] REQ_CANCEL  = 3'd4;
  localparam logic [2:0] REQ_CLEAR   = 3'd5;

  // Event codes of a result transaction
  localparam logic [2:0] EV_ACCEPTED  = 3'd0;
  localparam logic [2:0] EV_REPLIED   = 3'd1;
  localparam logic [2:0] EV_TIMEDOUT  = 3'd2;
  localparam logic [2:0] EV_CANCELLED = 3'd3;
  localparam logic [2:0] EV_NOMATCH   = 3'd4;
  localparam logic [2:0] EV_FULL      = 3'd5;

  // Descriptor values with a special meaning
  localparam logic [7:0] ANY_DESC = 8'hF1;
  localparam logic [7:0] NO_DESC  = 8'h00;

  localparam logic [31:0] BASE_TIMEOUT_RESET = 32'd1000;

endpackage

// File: rtl/command_reply_tracker_unit.sv
// Channel   Direction  Handshake            Payload
// in_       input      in_valid/in_ready    request code, timestamp, descriptors, slot
// out_      output     out_valid/out_ready  slot, event, ack code, length, flags
// cfg_      input      cfg_valid/cfg_ready  base timeout (32 bits)
//
// A transaction is latched in the idle cycle and decoded in the next; a sequencer
// then walks the order list one entry a cycle through a single compare/remove
// path, and each result waits in the output register until taken. Sent, reply
// and cancel scan up to the matching position; a reply then emits a timeout for
// each skipped entry before its own result; tick and clear emit one result per
// removed head, and codes 6 and 7 produce none. in_ready is high only while the
// sequencer is idle. Reset (rst_n low, synchronous) empties the list and disarms
// every slot.
module command_reply_tracker_unit #(
  parameter int QUEUE_DEPTH = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_req_type,
  input  logic [31:0] in_now,
  input  logic [7:0]  in_desc_set,
  input  logic [7:0]  in_field_desc,
  input  logic [7:0]  in_expect_desc,
  input  logic [7:0]  in_buffer_limit,
  input  logic [31:0] in_extra_wait,
  input  logic [7:0]  in_dev_ack,
  input  logic        in_next_valid,
  input  logic [7:0]  in_next_desc,
  input  logic [7:0]  in_next_len,
  input  logic [2:0]  in_slot_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_slot_out,
  output logic [2:0]  out_event_res,
  output logic [7:0]  out_reply_code,
  output logic [7:0]  out_resp_len,
  output logic        out_used_next,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  localparam int SW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    S_IDLE, S_DECODE, S_SCAN, S_REPLY, S_TICK, S_CLEAR, S_EMIT
  } state_t;

  state_t state_r, state_nxt, ret_r;

  // Latched request
  logic [2:0]  req_r;
  logic [31:0] now_r, extra_r;
  logic [7:0]  dset_r, dfield_r, expect_r, limit_r, ack_r, ndesc_r, nlen_r;
  logic        nvalid_r;
  logic [2:0]  sin_r;

  // Order list and slot stores
  logic [SW-1:0] order_r [QUEUE_DEPTH];
  logic [CW-1:0] count_r;
  logic [QUEUE_DEPTH-1:0] in_list_r, armed_r;
  logic [7:0]  set_r [QUEUE_DEPTH];
  logic [7:0]  field_r [QUEUE_DEPTH];
  logic [7:0]  sexp_r [QUEUE_DEPTH];
  logic [7:0]  slim_r [QUEUE_DEPTH];
  logic [31:0] sextra_r [QUEUE_DEPTH];
  logic [31:0] dl_r [QUEUE_DEPTH];
  logic [7:0]  stale_set_r, stale_field_r;
  logic [31:0] base_r;

  logic [CW-1:0] idx_r, hit_r;

  // Output register
  logic        ov_r, olast_r, oused_r;
  logic [2:0]  oslot_r, oev_r;
  logic [7:0]  ocode_r, olen_r;

  // Combinational helpers
  logic [SW-1:0] free_s, cur_s, h0, h1;
  logic [SW+2:0] sin_ext, cur_ext, h0_ext;
  logic [31:0]   d0, d1, deadline;
  logic          exp0, exp1, rm_en;
  logic [CW-1:0] rm_pos;
  logic [7:0]    rlen;
  logic          rused;

  // Pick lowest free slot
  always_comb begin
    free_s = '0;
    for (int j = QUEUE_DEPTH - 1; j >= 0; j--) begin
      if (!in_list_r[j]) free_s = SW'(j);
    end
  end

  assign cur_s   = order_r[idx_r[SW-1:0]];
  assign h0      = order_r[0];
  assign h1      = order_r[(QUEUE_DEPTH > 1) ? 1 : 0];
  assign sin_ext = {{SW{1'b0}}, sin_r};
  assign cur_ext = {3'b000, cur_s};
  assign h0_ext  = {3'b000, h0};

  // Wrap-aware expiry of the first two heads
  assign d0   = now_r - dl_r[h0];
  assign d1   = now_r - dl_r[h1];
  assign exp0 = (count_r != '0) && armed_r[h0] && (d0 != '0) && !d0[31];
  assign exp1 = (count_r > CW'(1)) && armed_r[h1] && (d1 != '0) && !d1[31];

  assign deadline = now_r + base_r + sextra_r[cur_s];

  // Response length of the reply at the head
  always_comb begin
    rlen  = '0;
    rused = 1'b0;
    if (sexp_r[h0] != crt_pkg::NO_DESC && ack_r == 8'd0 && nvalid_r &&
        (sexp_r[h0] == crt_pkg::ANY_DESC || ndesc_r == sexp_r[h0])) begin
      rlen  = nlen_r;
      rused = 1'b1;
    end
    if (rlen > slim_r[h0]) rlen = slim_r[h0];
  end

  // Removal request for the order list
  always_comb begin
    rm_en  = 1'b0;
    rm_pos = '0;
    unique case (state_r)
      S_SCAN: begin
        if (idx_r != count_r && req_r == crt_pkg::REQ_CANCEL &&
            cur_ext == sin_ext) begin
          rm_en  = 1'b1;
          rm_pos = idx_r;
        end
      end
      S_REPLY, S_CLEAR: rm_en = 1'b1;
      S_TICK:           rm_en = exp0;
      default:          rm_en = 1'b0;
    endcase
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (in_valid) state_nxt = S_DECODE;
      S_DECODE: begin
        unique case (req_r) inside
          crt_pkg::REQ_ENQUEUE: state_nxt = S_EMIT;
          crt_pkg::REQ_SENT, crt_pkg::REQ_REPLY, crt_pkg::REQ_CANCEL:
            state_nxt = S_SCAN;
          crt_pkg::REQ_TICK:  state_nxt = S_TICK;
          crt_pkg::REQ_CLEAR: state_nxt = (count_r == '0) ? S_IDLE : S_CLEAR;
          default:            state_nxt = S_IDLE;
        endcase
      end
      S_SCAN: begin
        if (idx_r == count_r) state_nxt = S_EMIT;
        else if (req_r == crt_pkg::REQ_SENT && !armed_r[cur_s]) state_nxt = S_EMIT;
        else if (req_r == crt_pkg::REQ_CANCEL && cur_ext == sin_ext) state_nxt = S_EMIT;
        else if (req_r == crt_pkg::REQ_REPLY && set_r[cur_s] == dset_r &&
                 field_r[cur_s] == dfield_r) begin
          state_nxt = (stale_set_r == dset_r && stale_field_r == dfield_r &&
                       idx_r != '0) ? S_EMIT : S_REPLY;
        end
      end
      S_REPLY, S_CLEAR: state_nxt = S_EMIT;
      S_TICK:           state_nxt = exp0 ? S_EMIT : S_IDLE;
      S_EMIT:           if (out_ready) state_nxt = olast_r ? S_IDLE : ret_r;
      default:          state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      ret_r         <= S_IDLE;
      count_r       <= '0;
      in_list_r     <= '0;
      armed_r       <= '0;
      stale_set_r   <= crt_pkg::NO_DESC;
      stale_field_r <= crt_pkg::NO_DESC;
      base_r        <= crt_pkg::BASE_TIMEOUT_RESET;
      ov_r          <= 1'b0;
      idx_r         <= '0;
      hit_r         <= '0;
    end else begin
      state_r <= state_nxt;
      if (cfg_valid) base_r <= cfg_data;

      // Latch the transaction
      if (state_r == S_IDLE && in_valid) begin
        req_r    <= in_req_type;
        now_r    <= in_now;
        dset_r   <= in_desc_set;
        dfield_r <= in_field_desc;
        expect_r <= in_expect_desc;
        limit_r  <= in_buffer_limit;
        extra_r  <= in_extra_wait;
        ack_r    <= in_dev_ack;
        nvalid_r <= in_next_valid;
        ndesc_r  <= in_next_desc;
        nlen_r   <= in_next_len;
        sin_r    <= in_slot_in;
        idx_r    <= '0;
      end

      // Drop one entry from the order list
      if (rm_en) begin
        for (int j = 0; j < QUEUE_DEPTH - 1; j++) begin
          if (CW'(j) >= rm_pos) order_r[j] <= order_r[j + 1];
        end
        count_r <= count_r - CW'(1);
        if (state_r == S_SCAN) begin
          in_list_r[cur_s] <= 1'b0;
          armed_r[cur_s]   <= 1'b0;
        end else begin
          in_list_r[h0] <= 1'b0;
          armed_r[h0]   <= 1'b0;
        end
      end

      // Default result fields
      if (state_r != S_EMIT && state_nxt == S_EMIT) begin
        ov_r    <= 1'b1;
        olast_r <= 1'b1;
        oslot_r <= 3'd0;
        ocode_r <= '0;
        olen_r  <= '0;
        oused_r <= 1'b0;
        ret_r   <= state_r;
      end

      unique case (state_r)
        S_DECODE: begin
          if (req_r == crt_pkg::REQ_ENQUEUE) begin
            if (count_r >= CW'(QUEUE_DEPTH)) begin
              oev_r <= crt_pkg::EV_FULL;
            end else begin
              set_r[free_s]    <= dset_r;
              field_r[free_s]  <= dfield_r;
              sexp_r[free_s]   <= expect_r;
              slim_r[free_s]   <= limit_r;
              sextra_r[free_s] <= extra_r;
              dl_r[free_s]     <= '0;
              armed_r[free_s]  <= 1'b0;
              in_list_r[free_s] <= 1'b1;
              order_r[count_r[SW-1:0]] <= free_s;
              count_r <= count_r + CW'(1);
              oslot_r <= 3'({3'b000, free_s});
              oev_r   <= crt_pkg::EV_ACCEPTED;
            end
          end
        end
        S_SCAN: begin
          if (idx_r == count_r) begin
            oev_r <= crt_pkg::EV_NOMATCH;
            if (req_r == crt_pkg::REQ_CANCEL) oslot_r <= sin_r;
          end else if (state_nxt == S_EMIT) begin
            if (req_r == crt_pkg::REQ_SENT) begin
              dl_r[cur_s]    <= deadline;
              armed_r[cur_s] <= 1'b1;
              oslot_r        <= cur_ext[2:0];
              oev_r          <= crt_pkg::EV_ACCEPTED;
            end else if (req_r == crt_pkg::REQ_CANCEL) begin
              oslot_r <= sin_r;
              oev_r   <= crt_pkg::EV_CANCELLED;
            end else begin
              oev_r <= crt_pkg::EV_NOMATCH;
            end
          end else if (state_nxt == S_REPLY) begin
            hit_r <= idx_r;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_REPLY: begin
          oslot_r <= h0_ext[2:0];
          if (hit_r != '0) begin
            hit_r   <= hit_r - CW'(1);
            oev_r   <= crt_pkg::EV_TIMEDOUT;
            olast_r <= 1'b0;
          end else begin
            oev_r   <= crt_pkg::EV_REPLIED;
            ocode_r <= ack_r;
            olen_r  <= rlen;
            oused_r <= rused;
          end
        end
        S_TICK: begin
          if (exp0) begin
            stale_set_r   <= set_r[h0];
            stale_field_r <= field_r[h0];
            oslot_r       <= h0_ext[2:0];
            oev_r         <= crt_pkg::EV_TIMEDOUT;
            olast_r       <= !exp1;
          end
        end
        S_CLEAR: begin
          oslot_r <= h0_ext[2:0];
          oev_r   <= crt_pkg::EV_CANCELLED;
          olast_r <= (count_r == CW'(1));
        end
        S_EMIT: if (out_ready) ov_r <= 1'b0;
        default: ;
      endcase
    end
  end

  assign in_ready       = (state_r == S_IDLE);
  assign cfg_ready      = 1'b1;
  assign out_valid      = ov_r;
  assign out_slot_out   = oslot_r;
  assign out_event_res  = oev_r;
  assign out_reply_code = ocode_r;
  assign out_resp_len   = olen_r;
  assign out_used_next  = oused_r;
  assign out_last       = olast_r;

endmodule

// File: rtl/crt_checker.sv
module crt_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_last,
  input logic [2:0] out_event_res
);

  // Never take a new transaction while a result is pending
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input ready while result pending");

  // Hold off input for the cycle after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready) else $error("ready after accept");

  // Stay busy after a result that is not the last one
  a_more_results: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_ready && !out_last) |=> !in_ready)
    else $error("ready before last result");

  // Hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_event_res)))
    else $error("stalled result changed");

endmodule

bind command_reply_tracker_unit crt_checker u_crt_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_last(out_last),
  .out_event_res(out_event_res)
);

// File: verif/tb.sv
`timescale 1ns / 100ps

module tb;

  localparam int DEPTH = 8;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic [2:0]  req_type;
    logic [31:0] ts;
    logic [7:0]  desc_set;
    logic [7:0]  field_desc;
    logic [7:0]  expect_desc;
    logic [7:0]  buffer_limit;
    logic [31:0] extra_wait;
    logic [7:0]  dev_ack;
    logic        next_valid;
    logic [7:0]  next_desc;
    logic [7:0]  next_len;
    logic [2:0]  slot_in;
  } cmd_req_t;

  typedef struct {
    logic [2:0] slot;
    logic [2:0] ev;
    logic [7:0] code;
    logic [7:0] len;
    logic       used;
    logic       is_last;
  } track_event_t;

  // Mirror of the command table; predicts the events of each request
  class tracker_scoreboard;
    logic [31:0]  base_wait;
    logic [2:0]   order_q[DEPTH];
    int           n_entries;
    logic [7:0]   e_set[DEPTH];
    logic [7:0]   e_field[DEPTH];
    logic [7:0]   e_expect[DEPTH];
    logic [7:0]   e_limit[DEPTH];
    logic [31:0]  e_extra[DEPTH];
    logic [31:0]  e_deadline[DEPTH];
    bit           e_armed[DEPTH];
    logic [7:0]   stale_set;
    logic [7:0]   stale_field;
    track_event_t expected_events[$];
    int           errors;

    function new();
      base_wait = crt_pkg::BASE_TIMEOUT_RESET;
      n_entries = 0;
      foreach (e_armed[i]) e_armed[i] = 0;
      stale_set = crt_pkg::NO_DESC;
      stale_field = crt_pkg::NO_DESC;
      errors = 0;
    endfunction

    function void emit(logic [2:0] slot, logic [2:0] ev, logic [7:0] code,
                       logic [7:0] len, logic used);
      track_event_t e;
      e.slot = slot; e.ev = ev; e.code = code; e.len = len; e.used = used;
      e.is_last = 0;
      expected_events.push_back(e);
    endfunction

    function int position_of(logic [2:0] slot);
      for (int i = 0; i < n_entries; i++)
        if (order_q[i] == slot) return i;
      return -1;
    endfunction

    function void remove_at(int pos);
      for (int i = pos; i + 1 < n_entries; i++) order_q[i] = order_q[i + 1];
      n_entries--;
    endfunction

    function bit has_expired(logic [2:0] slot, logic [31:0] ts);
      logic [31:0] d;
      d = ts - e_deadline[slot];
      return d != 0 && !d[31];
    endfunction

    function void note_request(cmd_req_t r);
      int start_size;
      int hit;
      int n;
      int pos;
      logic [2:0] s;
      logic [7:0] rlen;
      logic used;
      start_size = expected_events.size();
      n = 0;
      case (r.req_type)
        crt_pkg::REQ_ENQUEUE: begin
          if (n_entries >= DEPTH) begin
            emit(0, crt_pkg::EV_FULL, 0, 0, 0);
          end else begin
            s = 0;
            for (int k = 0; k < DEPTH; k++)
              if (position_of(3'(k)) < 0) begin
                s = 3'(k);
                break;
              end
            e_set[s] = r.desc_set;
            e_field[s] = r.field_desc;
            e_expect[s] = r.expect_desc;
            e_limit[s] = r.buffer_limit;
            e_extra[s] = r.extra_wait;
            e_deadline[s] = 0;
            e_armed[s] = 0;
            order_q[n_entries++] = s;
            emit(s, crt_pkg::EV_ACCEPTED, 0, 0, 0);
          end
        end
        crt_pkg::REQ_SENT: begin
          hit = -1;
          for (int i = 0; i < n_entries; i++)
            if (!e_armed[order_q[i]]) begin
              hit = i;
              break;
            end
          if (hit < 0) begin
            emit(0, crt_pkg::EV_NOMATCH, 0, 0, 0);
          end else begin
            s = order_q[hit];
            e_deadline[s] = r.ts + base_wait + e_extra[s];
            e_armed[s] = 1;
            emit(s, crt_pkg::EV_ACCEPTED, 0, 0, 0);
          end
        end
        crt_pkg::REQ_TICK: begin
          while (n_entries > 0 && n < DEPTH) begin
            s = order_q[0];
            if (!e_armed[s] || !has_expired(s, r.ts)) break;
            remove_at(0);
            e_armed[s] = 0;
            stale_set = e_set[s];
            stale_field = e_field[s];
            emit(s, crt_pkg::EV_TIMEDOUT, 0, 0, 0);
            n++;
          end
        end
        crt_pkg::REQ_REPLY: begin
          hit = -1;
          for (int i = 0; i < n_entries; i++)
            if (e_set[order_q[i]] == r.desc_set && e_field[order_q[i]] == r.field_desc) begin
              hit = i;
              break;
            end
          if (hit < 0 || (r.desc_set == stale_set && r.field_desc == stale_field
                          && hit != 0)) begin
            emit(0, crt_pkg::EV_NOMATCH, 0, 0, 0);
          end else begin
            // skipped entries time out without touching the stale pair
            for (int k = 0; k < hit; k++) begin
              s = order_q[0];
              remove_at(0);
              e_armed[s] = 0;
              emit(s, crt_pkg::EV_TIMEDOUT, 0, 0, 0);
            end
            s = order_q[0];
            remove_at(0);
            e_armed[s] = 0;
            rlen = 0;
            used = 0;
            if (e_expect[s] != crt_pkg::NO_DESC && r.dev_ack == 0 && r.next_valid) begin
              if (e_expect[s] == crt_pkg::ANY_DESC) e_expect[s] = r.next_desc;
              if (r.next_desc == e_expect[s]) begin
                rlen = r.next_len;
                used = 1;
              end
            end
            if (rlen > e_limit[s]) rlen = e_limit[s];
            emit(s, crt_pkg::EV_REPLIED, r.dev_ack, rlen, used);
          end
        end
        crt_pkg::REQ_CANCEL: begin
          pos = position_of(r.slot_in);
          if (pos < 0) begin
            emit(r.slot_in, crt_pkg::EV_NOMATCH, 0, 0, 0);
          end else begin
            remove_at(pos);
            e_armed[r.slot_in] = 0;
            emit(r.slot_in, crt_pkg::EV_CANCELLED, 0, 0, 0);
          end
        end
        crt_pkg::REQ_CLEAR: begin
          while (n_entries > 0) begin
            s = order_q[0];
            remove_at(0);
            e_armed[s] = 0;
            emit(s, crt_pkg::EV_CANCELLED, 0, 0, 0);
          end
        end
        default: ;
      endcase
      if (expected_events.size() > start_size)
        expected_events[expected_events.size() - 1].is_last = 1;
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
      errors++;
    endtask

    task check_event(track_event_t got);
      track_event_t want;
      if (expected_events.size() == 0) begin
        report("unexpected transaction, slot", 32'(got.slot), 0);
        return;
      end
      want = expected_events.pop_front();
      if (got.slot !== want.slot) report("slot_out", 32'(got.slot), 32'(want.slot));
      if (got.ev !== want.ev) report("event_res", 32'(got.ev), 32'(want.ev));
      if (got.code !== want.code) report("reply_code", 32'(got.code), 32'(want.code));
      if (got.len !== want.len) report("resp_len", 32'(got.len), 32'(want.len));
      if (got.used !== want.used) report("used_next", 32'(got.used), 32'(want.used));
      if (got.is_last !== want.is_last)
        report("last", 32'(got.is_last), 32'(want.is_last));
    endtask
  endclass

  logic        clk = 0;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_req_type;
  logic [31:0] in_now;
  logic [7:0]  in_desc_set;
  logic [7:0]  in_field_desc;
  logic [7:0]  in_expect_desc;
  logic [7:0]  in_buffer_limit;
  logic [31:0] in_extra_wait;
  logic [7:0]  in_dev_ack;
  logic        in_next_valid;
  logic [7:0]  in_next_desc;
  logic [7:0]  in_next_len;
  logic [2:0]  in_slot_in;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_slot_out;
  logic [2:0]  out_event_res;
  logic [7:0]  out_reply_code;
  logic [7:0]  out_resp_len;
  logic        out_used_next;
  logic        out_last;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [31:0] cfg_data;

  tracker_scoreboard sb = new();
  logic [31:0] ts_now = 0;
  int hold_off = 0;
  int cycles = 0;

  command_reply_tracker_unit #(.QUEUE_DEPTH(DEPTH)) uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_req_type(in_req_type),
    .in_now(in_now), .in_desc_set(in_desc_set), .in_field_desc(in_field_desc),
    .in_expect_desc(in_expect_desc), .in_buffer_limit(in_buffer_limit),
    .in_extra_wait(in_extra_wait), .in_dev_ack(in_dev_ack),
    .in_next_valid(in_next_valid), .in_next_desc(in_next_desc),
    .in_next_len(in_next_len), .in_slot_in(in_slot_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_slot_out(out_slot_out),
    .out_event_res(out_event_res), .out_reply_code(out_reply_code),
    .out_resp_len(out_resp_len), .out_used_next(out_used_next),
    .out_last(out_last),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Check every result transaction
  always @(posedge clk) begin
    track_event_t got;
    if (rst_n && out_valid && out_ready) begin
      got.slot = out_slot_out; got.ev = out_event_res; got.code = out_reply_code;
      got.len = out_resp_len; got.used = out_used_next; got.is_last = out_last;
      sb.check_event(got);
    end
  end

  // Receiver stall pattern: long hold-off when asked, else a changing duty cycle
  always @(negedge clk) begin
    if (hold_off > 0) begin
      out_ready = 0;
      hold_off--;
    end else begin
      case ((cycles / 64) % 4)
        0: out_ready = 1;
        1: out_ready = ($urandom_range(0, 1) == 0);
        2: out_ready = ($urandom_range(0, 3) == 0);
        default: out_ready = ($urandom_range(0, 7) != 0);
      endcase
    end
  end

  function cmd_req_t blank_req(logic [2:0] t);
    cmd_req_t r;
    r.req_type = t; r.ts = 0; r.desc_set = 0; r.field_desc = 0;
    r.expect_desc = crt_pkg::NO_DESC; r.buffer_limit = 0; r.extra_wait = 0;
    r.dev_ack = 0; r.next_valid = 0; r.next_desc = 0; r.next_len = 0; r.slot_in = 0;
    return r;
  endfunction

  // Offer one transaction and hold it until taken
  task send_req(cmd_req_t r);
    in_req_type = r.req_type; in_now = r.ts; in_desc_set = r.desc_set;
    in_field_desc = r.field_desc; in_expect_desc = r.expect_desc;
    in_buffer_limit = r.buffer_limit; in_extra_wait = r.extra_wait;
    in_dev_ack = r.dev_ack; in_next_valid = r.next_valid;
    in_next_desc = r.next_desc; in_next_len = r.next_len; in_slot_in = r.slot_in;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    @(negedge clk);
    in_valid = 0;
  endtask

  task write_base(logic [31:0] v);
    cfg_data = v;
    cfg_valid = 1;
    do @(posedge clk); while (!cfg_ready);
    sb.base_wait = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  // Wait for every expected event, then let the sequencer settle
  task drain();
    while (sb.expected_events.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  function cmd_req_t random_req();
    cmd_req_t r;
    int p;
    int idx;
    logic [2:0] s;
    // background noise so every bit moves; well-formed fields override it
    r.req_type = 0; r.ts = 0; r.desc_set = 8'($urandom); r.field_desc = 8'($urandom);
    r.expect_desc = 8'($urandom); r.buffer_limit = 8'($urandom);
    r.extra_wait = $urandom; r.dev_ack = 8'($urandom);
    r.next_valid = 1'($urandom); r.next_desc = 8'($urandom);
    r.next_len = 8'($urandom); r.slot_in = 3'($urandom);
    ts_now += $urandom_range(0, 1500);
    if ($urandom_range(0, 30) == 0) ts_now += $urandom;
    r.ts = ts_now;
    p = $urandom_range(0, 99);
    if (p < 25) begin
      r.req_type = crt_pkg::REQ_ENQUEUE;
      if ($urandom_range(0, 5) != 0) begin
        r.desc_set = 8'h80 | 8'($urandom_range(0, 1));
        r.field_desc = 8'($urandom_range(1, 4));
      end
      case ($urandom_range(0, 3))
        0: r.expect_desc = crt_pkg::NO_DESC;
        1: r.expect_desc = crt_pkg::ANY_DESC;
        2: r.expect_desc = 8'h10 | 8'($urandom_range(0, 1));
        default: ;
      endcase
      if ($urandom_range(0, 4) != 0) r.extra_wait = $urandom_range(0, 3000);
    end else if (p < 45) begin
      r.req_type = crt_pkg::REQ_SENT;
    end else if (p < 60) begin
      r.req_type = crt_pkg::REQ_TICK;
    end else if (p < 85) begin
      r.req_type = crt_pkg::REQ_REPLY;
      if (sb.n_entries > 0 && $urandom_range(0, 3) != 0) begin
        idx = $urandom_range(0, sb.n_entries - 1);
        s = sb.order_q[idx];
        r.desc_set = sb.e_set[s];
        r.field_desc = sb.e_field[s];
        if ($urandom_range(0, 1) == 0) r.next_desc = sb.e_expect[s];
      end else if ($urandom_range(0, 1) == 0) begin
        r.desc_set = sb.stale_set;
        r.field_desc = sb.stale_field;
      end
      if ($urandom_range(0, 3) != 0) r.dev_ack = 0;
      if ($urandom_range(0, 3) != 0) r.next_valid = 1;
    end else if (p < 93) begin
      r.req_type = crt_pkg::REQ_CANCEL;
    end else if (p < 96) begin
      r.req_type = crt_pkg::REQ_CLEAR;
    end else begin
      r.req_type = 3'($urandom_range(6, 7));
    end
    return r;
  endfunction

  // Random traffic in bursts; ignored request codes do not count
  task run_random(int n_items, bit no_gaps);
    int sent;
    int burst;
    cmd_req_t r;
    sent = 0;
    burst = $urandom_range(1, 12);
    while (sent < n_items) begin
      r = random_req();
      send_req(r);
      if (r.req_type <= crt_pkg::REQ_CLEAR) sent++;
      burst--;
      if (burst == 0) begin
        if (!no_gaps) repeat ($urandom_range(0, 6)) @(negedge clk);
        burst = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    cmd_req_t r;
    rst_n = 0; in_valid = 0; cfg_valid = 0; cfg_data = 0; out_ready = 0;
    in_req_type = 0; in_now = 0; in_desc_set = 0; in_field_desc = 0;
    in_expect_desc = 0; in_buffer_limit = 0; in_extra_wait = 0; in_dev_ack = 0;
    in_next_valid = 0; in_next_desc = 0; in_next_len = 0; in_slot_in = 0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;

    // Directed: empty clear, extreme fields, fill to full
    send_req(blank_req(crt_pkg::REQ_CLEAR));
    r = blank_req(crt_pkg::REQ_ENQUEUE);
    r.desc_set = 8'hFF; r.field_desc = 8'hFF; r.expect_desc = crt_pkg::ANY_DESC;
    r.extra_wait = 32'hFFFF_FFFF;
    send_req(r);
    r = blank_req(crt_pkg::REQ_ENQUEUE);
    r.buffer_limit = 8'hFF;
    send_req(r);
    for (int i = 1; i <= 6; i++) begin
      r = blank_req(crt_pkg::REQ_ENQUEUE);
      r.desc_set = 8'h80; r.field_desc = 8'(i); r.expect_desc = 8'h10;
      r.buffer_limit = 8'h20;
      send_req(r);
    end
    send_req(blank_req(crt_pkg::REQ_ENQUEUE));
    // arm two heads, then tick before and after they expire
    r = blank_req(crt_pkg::REQ_SENT); r.ts = 100;
    send_req(r);
    send_req(r);
    r = blank_req(crt_pkg::REQ_TICK); r.ts = 1099;
    send_req(r);
    r.ts = 1101;
    send_req(r);
    // reply skipping one entry, response clamped to buffer limit
    r = blank_req(crt_pkg::REQ_REPLY);
    r.desc_set = 8'h80; r.field_desc = 2; r.next_valid = 1;
    r.next_desc = 8'h10; r.next_len = 8'hFF;
    send_req(r);
    // stale pair matching an entry that is not the head
    send_req(blank_req(crt_pkg::REQ_ENQUEUE));
    send_req(blank_req(crt_pkg::REQ_REPLY));
    r = blank_req(crt_pkg::REQ_REPLY); r.desc_set = 8'h55; r.field_desc = 8'h55;
    send_req(r);
    r = blank_req(crt_pkg::REQ_CANCEL); r.slot_in = 7;
    send_req(r);
    send_req(r);
    send_req(blank_req(3'd6));
    send_req(blank_req(3'd7));
    send_req(blank_req(crt_pkg::REQ_CLEAR));
    send_req(blank_req(crt_pkg::REQ_SENT));
    // wildcard expectation takes whatever descriptor follows
    r = blank_req(crt_pkg::REQ_ENQUEUE);
    r.desc_set = 1; r.field_desc = 1; r.expect_desc = crt_pkg::ANY_DESC;
    r.buffer_limit = 8;
    send_req(r);
    r = blank_req(crt_pkg::REQ_REPLY);
    r.desc_set = 1; r.field_desc = 1; r.next_valid = 1; r.next_desc = 8'h33;
    r.next_len = 8'h40;
    send_req(r);
    drain();

    write_base(0);
    run_random(25, 0);
    drain();

    // Fill the block while the receiver holds off
    write_base(32'hFFFF_FFFF);
    hold_off = 300;
    run_random(25, 1);
    drain();

    write_base($urandom_range(1, 5000));
    run_random(25, 0);
    drain();
    run_random(20, 0);
    drain();
    write_base(crt_pkg::BASE_TIMEOUT_RESET);
    run_random(10, 0);

    while (sb.expected_events.size() != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (sb.errors == 0 && sb.expected_events.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
